[sv/kmp_pkg.sv]
// shared types and constants of the streaming kmp matcher
`timescale 1ns / 1ps

package kmp_pkg;

  localparam int BYTE_W     = 8;
  localparam int REQ_W      = 2;
  localparam int MSTART_W   = 16;
  localparam int START_W    = 16;
  localparam int QUEUE_DEPTH = 2;

  // request codes as they arrive on the input channel
  localparam logic [REQ_W-1:0] REQ_CLEAR    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_APPEND   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_NEW_TEXT = 2'd2;
  localparam logic [REQ_W-1:0] REQ_TEXT     = 2'd3;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [BYTE_W-1:0] data_byte;
  } in_t;

  typedef struct packed {
    logic                match;
    logic [MSTART_W-1:0] match_start;
    logic                pattern_rejected;
    logic                position_saturated;
  } out_t;

  // decoded operation handed from front to back
  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_APPEND,
    OP_NEW_TEXT,
    OP_TEXT
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [BYTE_W-1:0] data;
  } cmd_t;

  // back-end sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_AP_FETCH,
    ST_AP_CMP,
    ST_TX_CMP
  } state_t;

endpackage

[sv/kmp_front.sv]
// input stage: decodes request beats and buffers them in a short queue
`timescale 1ns / 1ps

module kmp_front
  import kmp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic cmd_valid,
  input  logic cmd_ready,
  output cmd_t cmd
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          q_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  cmd_t          dec;
  logic          push, pop;

  // classify the request type
  always_comb begin
    dec.data = in_data.data_byte;
    unique case (in_data.req_type)
      REQ_CLEAR:    dec.op = OP_CLEAR;
      REQ_APPEND:   dec.op = OP_APPEND;
      REQ_NEW_TEXT: dec.op = OP_NEW_TEXT;
      REQ_TEXT:     dec.op = OP_TEXT;
      default:      dec.op = OP_TEXT;
    endcase
  end

  assign in_ready  = (count_r != CW'(QUEUE_DEPTH));
  assign cmd_valid = (count_r != '0);
  assign cmd       = q_r[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;

  // queue pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= dec;
    end
  end

endmodule

[sv/kmp_back.sv]
// execution stage: pattern/failure memories, kmp sequencer and result register
`timescale 1ns / 1ps

module kmp_back
  import kmp_pkg::*;
#(
  parameter int PATTERN_MAX   = 32,
  parameter int POSITION_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  cmd_t               cmd,
  input  logic               cfg_we,
  input  logic [START_W-1:0] cfg_wdata,
  output logic               out_valid,
  input  logic               out_ready,
  output out_t               out_data
);

  localparam int AW = $clog2(PATTERN_MAX);
  localparam int LW = $clog2(PATTERN_MAX + 1);
  localparam int SW = (POSITION_BITS > MSTART_W) ? POSITION_BITS : MSTART_W;
  localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

  // pattern bytes and failure links; link of entry zero is implied minus one
  logic [BYTE_W-1:0] pat_mem  [PATTERN_MAX];
  logic [AW-1:0]     fail_mem [PATTERN_MAX];

  state_t             state_r, state_nxt;
  logic [LW-1:0]      len_r, len_nxt;
  logic [LW-1:0]      mcount_r, mcount_nxt;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic [START_W-1:0] start_pos_r;
  logic [AW-1:0]      cur_r, cur_nxt;
  logic [BYTE_W-1:0]  byte_r, byte_nxt;

  logic [BYTE_W-1:0]  pat_rd_r;
  logic [AW-1:0]      fail_rd_r;
  logic               rd_zero_r;
  logic [AW-1:0]      rd_addr;
  logic               pat_we;
  logic               fail_we;
  logic [AW-1:0]      fail_waddr;
  logic [AW-1:0]      fail_wdata;

  out_t               out_r;
  logic               out_valid_r;
  out_t               res;
  logic               res_we;
  logic               out_free;
  logic               ap_fin, tx_fin;
  logic [LW-1:0]      fin_val;
  logic               started;
  logic [SW-1:0]      mstart_full;

  assign out_free    = !out_valid_r || out_ready;
  assign started     = SW'(pos_r) >= SW'(start_pos_r);
  assign mstart_full = SW'(pos_r) + SW'(1) - SW'(len_r);

  // sequencer: one comparison per cycle, failure link fed straight back as address
  always_comb begin
    state_nxt  = state_r;
    len_nxt    = len_r;
    mcount_nxt = mcount_r;
    pos_nxt    = pos_r;
    cur_nxt    = cur_r;
    byte_nxt   = byte_r;
    rd_addr    = '0;
    pat_we     = 1'b0;
    fail_we    = 1'b0;
    fail_waddr = '0;
    fail_wdata = '0;
    res        = '0;
    res_we     = 1'b0;
    cmd_ready  = 1'b0;
    ap_fin     = 1'b0;
    tx_fin     = 1'b0;
    fin_val    = '0;

    unique case (state_r)
      ST_IDLE: begin
        cmd_ready = out_free;
        if (cmd_valid && out_free) begin
          unique case (cmd.op)
            OP_CLEAR: begin
              len_nxt    = '0;
              mcount_nxt = '0;
              res_we     = 1'b1;
            end
            OP_APPEND: begin
              if (len_r == LW'(PATTERN_MAX)) begin
                res_we               = 1'b1;
                res.pattern_rejected = 1'b1;
              end else begin
                pat_we    = 1'b1;
                byte_nxt  = cmd.data;
                rd_addr   = len_r[AW-1:0];
                state_nxt = ST_AP_FETCH;
              end
            end
            OP_NEW_TEXT: begin
              pos_nxt    = '0;
              mcount_nxt = '0;
              res_we     = 1'b1;
            end
            OP_TEXT: begin
              if (pos_r == POS_MAX) begin
                res_we = 1'b1;
              end else if (!started || len_r == '0) begin
                pos_nxt = pos_r + 1'b1;
                res_we  = 1'b1;
              end else begin
                byte_nxt  = cmd.data;
                cur_nxt   = (mcount_r < len_r) ? mcount_r[AW-1:0] : '0;
                rd_addr   = cur_nxt;
                state_nxt = ST_TX_CMP;
              end
            end
            default: begin
              res_we = 1'b1;
            end
          endcase
        end
      end
      ST_AP_FETCH: begin
        if (rd_zero_r) begin
          ap_fin = 1'b1;
        end else begin
          cur_nxt   = fail_rd_r;
          rd_addr   = fail_rd_r;
          state_nxt = ST_AP_CMP;
        end
      end
      ST_AP_CMP: begin
        if (pat_rd_r == byte_r) begin
          ap_fin  = 1'b1;
          fin_val = LW'(cur_r) + 1'b1;
        end else if (rd_zero_r) begin
          ap_fin = 1'b1;
        end else begin
          cur_nxt = fail_rd_r;
          rd_addr = fail_rd_r;
        end
      end
      ST_TX_CMP: begin
        if (pat_rd_r == byte_r) begin
          tx_fin  = 1'b1;
          fin_val = LW'(cur_r) + 1'b1;
        end else if (rd_zero_r) begin
          tx_fin = 1'b1;
        end else begin
          cur_nxt = fail_rd_r;
          rd_addr = fail_rd_r;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // close an append: store the new link unless it lies past the last readable entry
    if (ap_fin) begin
      if (len_r != LW'(PATTERN_MAX - 1)) begin
        fail_we    = 1'b1;
        fail_waddr = len_r[AW-1:0] + 1'b1;
        fail_wdata = fin_val[AW-1:0];
      end
      len_nxt   = len_r + 1'b1;
      res_we    = 1'b1;
      state_nxt = ST_IDLE;
    end

    // close a text byte: full match restarts at an empty prefix
    if (tx_fin) begin
      if (fin_val == len_r) begin
        res.match       = 1'b1;
        res.match_start = mstart_full[MSTART_W-1:0];
        mcount_nxt      = '0;
      end else begin
        mcount_nxt = fin_val;
      end
      pos_nxt   = pos_r + 1'b1;
      res_we    = 1'b1;
      state_nxt = ST_IDLE;
    end

    res.position_saturated = (pos_nxt == POS_MAX);
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      len_r       <= '0;
      mcount_r    <= '0;
      pos_r       <= '0;
      start_pos_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      len_r    <= len_nxt;
      mcount_r <= mcount_nxt;
      pos_r    <= pos_nxt;
      if (cfg_we) begin
        start_pos_r <= cfg_wdata;
      end
      if (res_we) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // working registers and result payload
  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    byte_r <= byte_nxt;
    if (res_we) begin
      out_r <= res;
    end
  end

  // memories with registered read
  always_ff @(posedge clk) begin
    if (pat_we) begin
      pat_mem[len_r[AW-1:0]] <= cmd.data;
    end
    if (fail_we) begin
      fail_mem[fail_waddr] <= fail_wdata;
    end
    pat_rd_r  <= pat_mem[rd_addr];
    fail_rd_r <= fail_mem[rd_addr];
    rd_zero_r <= (rd_addr == '0);
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // pattern length never exceeds the store
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LW'(PATTERN_MAX))
    else $error("pattern length beyond store");

  // matched prefix is always shorter than the pattern, or else empty
  a_mcount_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (mcount_r < len_r) || (mcount_r == '0))
    else $error("matched prefix not below pattern length");

  // a search in progress owns an empty result slot
  a_busy_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !out_valid_r)
    else $error("result slot occupied during search");

  // a new command is only taken by an idle sequencer
  a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_valid && cmd_ready) |-> (state_r == ST_IDLE))
    else $error("command taken while busy");

  // a match result never carries a rejection
  a_match_excl: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.match) |-> !out_r.pattern_rejected)
    else $error("match and reject in one result");

endmodule

[sv/kmp_stream_matcher.sv]
// top level of the streaming kmp matcher
//
// Input beats (in_valid/in_ready, in_data) carry a request type and a byte:
// clear pattern, append pattern byte, start new text, or text byte. Every
// accepted beat gives exactly one result beat (out_valid/out_ready, out_data)
// with match, match_start, pattern_rejected and position_saturated.
// cfg_we/cfg_wdata write start_position; text bytes below it are counted
// but not compared. Write it only while the block is idle.
// Beats enter a two-entry queue, so the input keeps taking beats while a
// result waits. A clear, new-text, rejected append or skipped text byte
// gives its result without a pattern comparison. A compared text byte
// makes one pattern comparison per cycle (the failure-link loop reads the
// pattern and link memories once per cycle); an append makes one link
// fetch and then its comparisons. Beats that need no comparison sustain
// one per cycle while out_ready stays high; failure steps amortize to two
// compares per text byte.
// Reset (rst_n low, synchronous) empties the queue and result register and
// clears the pattern length, matched prefix, position and start_position.
// When out_ready is low the result is held; the sequencer waits and the
// queue fills, after which in_ready drops.
`timescale 1ns / 1ps

module kmp_stream_matcher
  import kmp_pkg::*;
#(
  parameter int PATTERN_MAX   = 32,
  parameter int POSITION_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  in_t                in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output out_t               out_data,
  input  logic               cfg_we,
  input  logic [START_W-1:0] cfg_wdata
);

  cmd_t cmd;
  logic cmd_valid;
  logic cmd_ready;

  // request decode and queue
  kmp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  // matching engine and result register
  kmp_back #(
    .PATTERN_MAX   (PATTERN_MAX),
    .POSITION_BITS (POSITION_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
